// ===== sv/imu_swd_pkg.sv =====
// Shared constants, types and helpers for the IMU static window detector.
package imu_swd_pkg;

    localparam int HALF_WINDOW = 100;
    localparam int FULL_WINDOW = 2 * HALF_WINDOW;

    localparam int SMP_W  = 16;                      // sample field width
    localparam int CFG_W  = 15;                      // config register width
    localparam int AP_W   = $clog2(FULL_WINDOW);     // accel ring address
    localparam int RP_W   = $clog2(HALF_WINDOW);     // rate verdict ring address
    localparam int FILL_W = $clog2(FULL_WINDOW + 1); // fill count, holds 2*H
    localparam int N_W    = FILL_W;                  // width of the window length
    localparam int SUM_W  = SMP_W + AP_W;            // signed running sum
    localparam int SQ_W   = 2 * SMP_W - 1 + AP_W;    // running sum of squares
    localparam int RSQ_W  = 2 * SMP_W - 1;           // one square, max 2^30
    localparam int RN_W   = RSQ_W + 2;               // sum of three squares
    localparam int LIM_W  = CFG_W + N_W;             // spread limit * n
    localparam int HI_W   = CFG_W + 1 + N_W;         // (gravity + tol) * n
    localparam int VW     = 2 * SUM_W + 2;           // verdict arithmetic width

    localparam logic [N_W-1:0] N_CONST = N_W'(FULL_WINDOW);

    localparam logic [CFG_W-1:0] RATE_LIMIT_RST        = CFG_W'(164);
    localparam logic [CFG_W-1:0] SPREAD_LIMIT_RST      = CFG_W'(164);
    localparam logic [CFG_W-1:0] GRAVITY_LEVEL_RST     = CFG_W'(10045);
    localparam logic [CFG_W-1:0] GRAVITY_TOLERANCE_RST = CFG_W'(307);

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_LIMIT        = 2'd0,
        CFG_SPREAD_LIMIT      = 2'd1,
        CFG_GRAVITY_LEVEL     = 2'd2,
        CFG_GRAVITY_TOLERANCE = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] z;
        logic signed [SMP_W-1:0] y;
        logic signed [SMP_W-1:0] x;
    } accel_vec_t;

    function automatic logic [RSQ_W-1:0] sq16(input logic signed [SMP_W-1:0] v);
        logic signed [2*SMP_W-1:0] p;
        p = v * v;
        return p[RSQ_W-1:0];
    endfunction

endpackage

// ===== sv/imu_static_window_detector_core.sv =====
// IMU static window detector: ring memories, running sums and stillness verdict pipeline.
// Pipeline: a result passes through the squares, running-sum, squared-sum, spread and
//   compare stages into the output register; stalls on the result side hold the whole pipeline.
// Throughput: one sample per cycle unless the result side stalls; each sample does one
//   read-write of the accel ring (at transfer) and one of the rate verdict ring (stage 2).
// Reset (aresetn, synchronous): clears sums, fill count, ring positions and pipeline
//   valids and restores default thresholds; ring contents are left as they are.
module imu_static_window_detector_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [imu_swd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [imu_swd_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_restart,
    input  logic signed [imu_swd_pkg::SMP_W-1:0]   s_accel_x,
    input  logic signed [imu_swd_pkg::SMP_W-1:0]   s_accel_y,
    input  logic signed [imu_swd_pkg::SMP_W-1:0]   s_accel_z,
    input  logic signed [imu_swd_pkg::SMP_W-1:0]   s_rate_x,
    input  logic signed [imu_swd_pkg::SMP_W-1:0]   s_rate_y,
    input  logic signed [imu_swd_pkg::SMP_W-1:0]   s_rate_z,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_valid_res,
    output logic                                   m_is_static
);
    import imu_swd_pkg::*;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] rate_limit_reg, spread_limit_reg;
    logic [CFG_W-1:0] gravity_level_reg, gravity_tolerance_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_limit_reg        <= RATE_LIMIT_RST;
            spread_limit_reg      <= SPREAD_LIMIT_RST;
            gravity_level_reg     <= GRAVITY_LEVEL_RST;
            gravity_tolerance_reg <= GRAVITY_TOLERANCE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_RATE_LIMIT:        rate_limit_reg        <= cfg_data;
                CFG_SPREAD_LIMIT:      spread_limit_reg      <= cfg_data;
                CFG_GRAVITY_LEVEL:     gravity_level_reg     <= cfg_data;
                CFG_GRAVITY_TOLERANCE: gravity_tolerance_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Thresholds squared and scaled by the window length; refreshed every cycle.
    logic [CFG_W:0]       gt_sum;
    logic [CFG_W-1:0]     gt_diff;
    logic [2*CFG_W-1:0]   rl_prod;
    logic [LIM_W-1:0]     lim_scaled;
    logic [HI_W-1:0]      hi_scaled;
    logic [LIM_W-1:0]     lo_scaled;
    logic [2*CFG_W-1:0]   rl_sq_reg;
    logic [LIM_W-1:0]     lim_reg, lo_reg;
    logic [HI_W-1:0]      hi_reg;
    logic                 lo_en_reg;
    logic [2*LIM_W-1:0]   lim_prod, lo_prod;
    logic [2*HI_W-1:0]    hi_prod;
    logic [VW-1:0]        lim_sq_reg, hi_sq_reg, lo_sq_reg;

    assign gt_sum     = {1'b0, gravity_level_reg} + {1'b0, gravity_tolerance_reg};
    assign gt_diff    = gravity_level_reg - gravity_tolerance_reg;
    assign rl_prod    = rate_limit_reg * rate_limit_reg;
    assign lim_scaled = spread_limit_reg * N_CONST;
    assign hi_scaled  = gt_sum * N_CONST;
    assign lo_scaled  = gt_diff * N_CONST;
    assign lim_prod   = lim_reg * lim_reg;
    assign hi_prod    = hi_reg * hi_reg;
    assign lo_prod    = lo_reg * lo_reg;

    always_ff @(posedge aclk) begin
        rl_sq_reg  <= rl_prod;
        lim_reg    <= lim_scaled;
        hi_reg     <= hi_scaled;
        lo_reg     <= lo_scaled;
        lo_en_reg  <= (gravity_level_reg >= gravity_tolerance_reg);
        lim_sq_reg <= VW'(lim_prod);
        hi_sq_reg  <= VW'(hi_prod);
        lo_sq_reg  <= VW'(lo_prod);
    end

    // ---------------- input stage ----------------
    logic              en, accept;
    logic [FILL_W-1:0] fill_count_reg, fill_count_next, fill0;
    logic [AP_W-1:0]   accel_pos_reg, accel_pos_next, ap0;
    logic [RP_W-1:0]   rate_pos_reg, rate_pos_next, rp0;
    logic              val0, full0;
    accel_vec_t        accel_in;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign accept  = s_valid && s_ready;

    assign accel_in = '{z: s_accel_z, y: s_accel_y, x: s_accel_x};

    always_comb begin
        fill0 = s_restart ? '0 : fill_count_reg;
        ap0   = s_restart ? '0 : accel_pos_reg;
        rp0   = s_restart ? '0 : rate_pos_reg;
        val0  = (fill0 >= FILL_W'(HALF_WINDOW));
        full0 = (fill0 >= FILL_W'(FULL_WINDOW));
        fill_count_next = fill_count_reg;
        accel_pos_next  = accel_pos_reg;
        rate_pos_next   = rate_pos_reg;
        if (accept) begin
            fill_count_next = full0 ? fill0 : fill0 + 1'b1;
            accel_pos_next  = (ap0 == AP_W'(FULL_WINDOW - 1)) ? '0 : ap0 + 1'b1;
            rate_pos_next   = (rp0 == RP_W'(HALF_WINDOW - 1)) ? '0 : rp0 + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
            accel_pos_reg  <= '0;
            rate_pos_reg   <= '0;
        end else begin
            fill_count_reg <= fill_count_next;
            accel_pos_reg  <= accel_pos_next;
            rate_pos_reg   <= rate_pos_next;
        end
    end

    // Accel ring: read-first, so the same access returns the sample leaving the window.
    accel_vec_t accel_mem [FULL_WINDOW];
    accel_vec_t accel_old_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            accel_old_reg   <= accel_mem[ap0];
            accel_mem[ap0]  <= accel_in;
        end
    end

    // ---------------- pipeline valids ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= accept;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            m_valid_reg <= v5_reg;
        end
    end

    // ---------------- stage 1: squares ----------------
    logic                    rst1_reg, val1_reg, full1_reg;
    logic [RP_W-1:0]         rp1_reg;
    logic signed [SMP_W-1:0] a1_reg [3];
    logic signed [SMP_W-1:0] r1_reg [3];
    logic signed [SMP_W-1:0] old1 [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            rst1_reg  <= s_restart;
            val1_reg  <= val0;
            full1_reg <= full0;
            rp1_reg   <= rp0;
            a1_reg[0] <= s_accel_x;
            a1_reg[1] <= s_accel_y;
            a1_reg[2] <= s_accel_z;
            r1_reg[0] <= s_rate_x;
            r1_reg[1] <= s_rate_y;
            r1_reg[2] <= s_rate_z;
        end
    end

    assign old1[0] = accel_old_reg.x;
    assign old1[1] = accel_old_reg.y;
    assign old1[2] = accel_old_reg.z;

    logic                    rst2_reg, val2_reg, full2_reg;
    logic [RP_W-1:0]         rp2_reg;
    logic signed [SMP_W-1:0] a2_reg [3];
    logic signed [SMP_W-1:0] old2_reg [3];
    logic [RSQ_W-1:0]        sqa2_reg [3];
    logic [RSQ_W-1:0]        sqo2_reg [3];
    logic [RSQ_W-1:0]        rsq2_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            rst2_reg  <= rst1_reg;
            val2_reg  <= val1_reg;
            full2_reg <= full1_reg;
            rp2_reg   <= rp1_reg;
            for (int k = 0; k < 3; k++) begin
                a2_reg[k]   <= a1_reg[k];
                old2_reg[k] <= old1[k];
                sqa2_reg[k] <= sq16(a1_reg[k]);
                sqo2_reg[k] <= sq16(old1[k]);
                rsq2_reg[k] <= sq16(r1_reg[k]);
            end
        end
    end

    // ---------------- stage 2: running sums, rate verdict ring ----------------
    logic signed [SUM_W-1:0] acc_sum_reg [3];
    logic signed [SUM_W-1:0] acc_sum_next [3];
    logic signed [SUM_W-1:0] sum_base [3];
    logic [SQ_W-1:0]         sq_sum_reg [3];
    logic [SQ_W-1:0]         sq_sum_next [3];
    logic [SQ_W-1:0]         sq_base [3];
    logic [RN_W-1:0]         rn2;
    logic                    cur_ok2;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum_base[k]     = rst2_reg ? '0 : acc_sum_reg[k];
            sq_base[k]      = rst2_reg ? '0 : sq_sum_reg[k];
            acc_sum_next[k] = sum_base[k] + SUM_W'(a2_reg[k])
                              - (full2_reg ? SUM_W'(old2_reg[k]) : SUM_W'(0));
            sq_sum_next[k]  = sq_base[k] + SQ_W'(sqa2_reg[k])
                              - (full2_reg ? SQ_W'(sqo2_reg[k]) : SQ_W'(0));
        end
        rn2     = RN_W'(rsq2_reg[0]) + RN_W'(rsq2_reg[1]) + RN_W'(rsq2_reg[2]);
        cur_ok2 = (rn2 < RN_W'(rl_sq_reg));
    end

    // sums cover the window before this sample; a restart sample starts from zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                acc_sum_reg[k] <= '0;
                sq_sum_reg[k]  <= '0;
            end
        end else if (en && v2_reg) begin
            for (int k = 0; k < 3; k++) begin
                acc_sum_reg[k] <= acc_sum_next[k];
                sq_sum_reg[k]  <= sq_sum_next[k];
            end
        end
    end

    // Rate verdict ring: read-first, returns the verdict of the sample H back.
    logic rate_ok_mem [HALF_WINDOW];
    logic ok_rd_reg;

    always_ff @(posedge aclk) begin
        if (en && v2_reg) begin
            ok_rd_reg              <= rate_ok_mem[rp2_reg];
            rate_ok_mem[rp2_reg]   <= cur_ok2;
        end
    end

    logic                    val3_reg, full3_reg;
    logic signed [SUM_W-1:0] sumb3_reg [3];
    logic [SQ_W-1:0]         sqb3_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            val3_reg  <= val2_reg;
            full3_reg <= full2_reg;
            for (int k = 0; k < 3; k++) begin
                sumb3_reg[k] <= sum_base[k];
                sqb3_reg[k]  <= sq_base[k];
            end
        end
    end

    // ---------------- stage 3: squared sums and scaled square sums ----------------
    logic [SUM_W-1:0]        abs3 [3];
    logic [2*SUM_W-1:0]      s2_prod [3];
    logic [SQ_W+N_W-1:0]     nq_prod [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            abs3[k]    = sumb3_reg[k][SUM_W-1] ? SUM_W'(-sumb3_reg[k]) : SUM_W'(sumb3_reg[k]);
            s2_prod[k] = abs3[k] * abs3[k];
            nq_prod[k] = sqb3_reg[k] * N_CONST;
        end
    end

    logic          val4_reg, full4_reg, ok4_reg;
    logic [VW-1:0] s2_4_reg [3];
    logic [VW-1:0] nq4_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            val4_reg  <= val3_reg;
            full4_reg <= full3_reg;
            ok4_reg   <= val3_reg && ok_rd_reg;
            for (int k = 0; k < 3; k++) begin
                s2_4_reg[k] <= VW'(s2_prod[k]);
                nq4_reg[k]  <= VW'(nq_prod[k]);
            end
        end
    end

    // ---------------- stage 4: per-axis spread, magnitude sum ----------------
    logic          val5_reg, full5_reg, ok5_reg;
    logic [VW-1:0] diff5_reg [3];
    logic [VW-1:0] mag5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            val5_reg  <= val4_reg;
            full5_reg <= full4_reg;
            ok5_reg   <= ok4_reg;
            for (int k = 0; k < 3; k++) begin
                // rounding of the squared sums can't make variance negative; clamp anyway
                diff5_reg[k] <= (nq4_reg[k] > s2_4_reg[k]) ? nq4_reg[k] - s2_4_reg[k] : '0;
            end
            mag5_reg <= s2_4_reg[0] + s2_4_reg[1] + s2_4_reg[2];
        end
    end

    // ---------------- stage 5: threshold compares ----------------
    logic [VW-1:0] spread5;
    logic          still5;

    always_comb begin
        spread5 = diff5_reg[0] + diff5_reg[1] + diff5_reg[2];
        still5  = full5_reg && ok5_reg
                  && (spread5 < lim_sq_reg)
                  && (mag5_reg < hi_sq_reg)
                  && (!lo_en_reg || (mag5_reg > lo_sq_reg));
    end

    logic valid_res_reg, is_static_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            valid_res_reg <= val5_reg;
            is_static_reg <= still5;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_valid_res = valid_res_reg;
    assign m_is_static = is_static_reg;

    // ---------------- assertions ----------------
    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= FILL_W'(FULL_WINDOW))
        else $error("fill count beyond window length");

    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (accel_pos_reg < AP_W'(FULL_WINDOW)) && (rate_pos_reg < RP_W'(HALF_WINDOW)))
        else $error("ring position out of range");

    a_restart_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_restart) |=> (fill_count_reg == FILL_W'(1)))
        else $error("restart transfer did not start a new run");

    a_static_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_static) |-> m_valid_res)
        else $error("static verdict without a valid delayed sample");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the IMU static window detector core.
module testbench;
    import imu_swd_pkg::*;

    localparam int N_DIRECTED      = 25;
    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 280;
    localparam int MAX_GAP         = 7;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_LIMIT     = 1000;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic       restart;
        accel_vec_t acc;
        accel_vec_t rate;
    } imu_sample_t;

    typedef struct packed {
        logic valid_res;
        logic is_static;
    } verdict_t;

    typedef struct packed {
        imu_sample_t smp;
        logic        known;
        verdict_t    want;
    } directed_row_t;

    typedef struct packed {
        logic [CFG_W-1:0] rate;
        logic [CFG_W-1:0] spread;
        logic [CFG_W-1:0] grav;
        logic [CFG_W-1:0] tol;
    } thresholds_t;

    typedef enum int {SEG_STILL, SEG_MOTION, SEG_NOISE, SEG_CORNER} seg_kind_t;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    cfg_we;
    cfg_index_t              cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_restart;
    logic signed [SMP_W-1:0] s_accel_x, s_accel_y, s_accel_z;
    logic signed [SMP_W-1:0] s_rate_x, s_rate_y, s_rate_z;
    logic                    m_valid;
    logic                    m_ready;
    logic                    m_valid_res;
    logic                    m_is_static;

    // stillness predictor state
    logic signed [SMP_W-1:0] acc_hist [FULL_WINDOW][3];
    bit                      rate_ok_hist [HALF_WINDOW];
    longint                  acc_sum [3];
    longint unsigned         acc_sq_sum [3];
    int unsigned             fill_cnt, acc_wr, rate_wr;
    logic [CFG_W-1:0]        rate_lim, spread_lim, grav_lvl, grav_tol;

    verdict_t      verdicts_due [$];
    directed_row_t dir_tab [N_DIRECTED];

    bit          tx_quiet     = 1'b0;
    bit          rx_quiet     = 1'b0;
    bit          rx_hold_req  = 1'b0;
    int unsigned samples_in   = 0;
    int unsigned verdicts_seen = 0;
    int unsigned full_seen    = 0;
    int unsigned statics_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned stall_cycles = 0;

    imu_static_window_detector_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_restart   (s_restart),
        .s_accel_x   (s_accel_x),
        .s_accel_y   (s_accel_y),
        .s_accel_z   (s_accel_z),
        .s_rate_x    (s_rate_x),
        .s_rate_y    (s_rate_y),
        .s_rate_z    (s_rate_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_valid_res (m_valid_res),
        .m_is_static (m_is_static)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void clear_window_history();
        int k;
        for (k = 0; k < 3; k++) begin
            acc_sum[k]    = 0;
            acc_sq_sum[k] = 0;
        end
        fill_cnt = 0;
        acc_wr   = 0;
        rate_wr  = 0;
    endfunction

    // all tests squared on both sides, scaled by the window length n
    function automatic bit window_is_still();
        longint unsigned n, spread_n2, mag_n2, s2, nq, lim, hi, lo;
        int k;
        n         = FULL_WINDOW;
        spread_n2 = 0;
        mag_n2    = 0;
        for (k = 0; k < 3; k++) begin
            s2 = acc_sum[k] * acc_sum[k];
            nq = n * acc_sq_sum[k];
            if (nq > s2) spread_n2 += nq - s2;
            mag_n2 += s2;
        end
        lim = n * 64'(spread_lim);
        hi  = n * (64'(grav_lvl) + 64'(grav_tol));
        if (spread_n2 >= lim * lim) return 1'b0;
        if (mag_n2 >= hi * hi) return 1'b0;
        // no lower bound once the tolerance exceeds the gravity level
        if (grav_lvl >= grav_tol) begin
            lo = n * (64'(grav_lvl) - 64'(grav_tol));
            if (mag_n2 <= lo * lo) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic verdict_t stillness_step(imu_sample_t s);
        verdict_t        v;
        longint          a [3];
        longint          r [3];
        longint          old;
        longint unsigned rate_n2;
        bit              full, cur_ok;
        int              k;
        a[0] = $signed(s.acc.x);
        a[1] = $signed(s.acc.y);
        a[2] = $signed(s.acc.z);
        r[0] = $signed(s.rate.x);
        r[1] = $signed(s.rate.y);
        r[2] = $signed(s.rate.z);
        if (s.restart) clear_window_history();
        full        = fill_cnt >= FULL_WINDOW;
        v.valid_res = fill_cnt >= HALF_WINDOW;
        v.is_static = full && v.valid_res && rate_ok_hist[rate_wr] && window_is_still();

        rate_n2 = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
        cur_ok  = rate_n2 < 64'(rate_lim) * 64'(rate_lim);
        rate_ok_hist[rate_wr] = cur_ok;
        rate_wr = (rate_wr + 1) % HALF_WINDOW;

        for (k = 0; k < 3; k++) begin
            if (full) begin
                old = acc_hist[acc_wr][k];
                acc_sum[k]    -= old;
                acc_sq_sum[k] -= old * old;
            end
            acc_hist[acc_wr][k] = SMP_W'(a[k]);
            acc_sum[k]    += a[k];
            acc_sq_sum[k] += a[k] * a[k];
        end
        acc_wr = (acc_wr + 1) % FULL_WINDOW;
        if (fill_cnt < FULL_WINDOW) fill_cnt++;
        return v;
    endfunction

    function automatic directed_row_t mk_row(
        input int rs,
        input logic [SMP_W-1:0] ax, input logic [SMP_W-1:0] ay, input logic [SMP_W-1:0] az,
        input logic [SMP_W-1:0] rx, input logic [SMP_W-1:0] ry, input logic [SMP_W-1:0] rz,
        input int known, input int want_valid, input int want_static);
        directed_row_t row;
        row.smp.restart     = (rs != 0);
        row.smp.acc.x       = ax;
        row.smp.acc.y       = ay;
        row.smp.acc.z       = az;
        row.smp.rate.x      = rx;
        row.smp.rate.y      = ry;
        row.smp.rate.z      = rz;
        row.known           = (known != 0);
        row.want.valid_res  = (want_valid != 0);
        row.want.is_static  = (want_static != 0);
        return row;
    endfunction

    function automatic logic [SMP_W-1:0] around(int centre, int span);
        int v;
        v = centre + int'($urandom_range(0, 2 * span)) - span;
        return SMP_W'(v);
    endfunction

    function automatic logic [SMP_W-1:0] corner_value();
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("MISMATCH at verdict %0d: %s", verdicts_seen, msg);
    endfunction

    task automatic send_sample(imu_sample_t s, logic known, verdict_t want);
        int unsigned gap;
        verdict_t    model_v;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_restart <= s.restart;
        s_accel_x <= s.acc.x;
        s_accel_y <= s.acc.y;
        s_accel_z <= s.acc.z;
        s_rate_x  <= s.rate.x;
        s_rate_y  <= s.rate.y;
        s_rate_z  <= s.rate.z;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        model_v = stillness_step(s);
        verdicts_due.insert(verdicts_due.size(), known ? want : model_v);
        samples_in++;
        @(negedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_RATE_LIMIT:        rate_lim   = val;
            CFG_SPREAD_LIMIT:      spread_lim = val;
            CFG_GRAVITY_LEVEL:     grav_lvl   = val;
            CFG_GRAVITY_TOLERANCE: grav_tol   = val;
            default: ;
        endcase
    endtask

    // block holds no work once every verdict is back
    task automatic settle_idle();
        s_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // mostly still stretches, some long enough to fill a window, plus motion, noise and corners
    task automatic run_random(int unsigned count);
        int unsigned left, seg_len, i, spread, rate_sp, pick;
        int          g, bx, by, bz;
        bit          fresh_run;
        seg_kind_t   seg_kind;
        imu_sample_t s;
        verdict_t    none;
        none = '0;
        left = count;
        while (left != 0) begin
            pick = $urandom_range(0, 19);
            if (pick < 12)      seg_kind = SEG_STILL;
            else if (pick < 15) seg_kind = SEG_MOTION;
            else if (pick < 18) seg_kind = SEG_NOISE;
            else                seg_kind = SEG_CORNER;
            tx_quiet  = ($urandom_range(0, 3) == 0);
            rx_quiet  = ($urandom_range(0, 3) == 0);
            spread    = $urandom_range(0, 250);
            rate_sp   = $urandom_range(0, 150);
            fresh_run = ($urandom_range(0, 7) == 0);
            g         = 10045 + int'($urandom_range(0, 800)) - 400;
            case ($urandom_range(0, 5))
                0:       begin bx = 0;              by = 0;  bz = g;               end
                1:       begin bx = 0;              by = 0;  bz = -g;              end
                2:       begin bx = g;              by = 0;  bz = 0;               end
                3:       begin bx = 0;              by = -g; bz = 0;               end
                4:       begin bx = g * 577 / 1000; by = bx; bz = bx;              end
                default: begin bx = g * 707 / 1000; by = 0;  bz = -g * 707 / 1000; end
            endcase
            case (seg_kind)
                SEG_STILL:  seg_len = $urandom_range(40, 260);
                SEG_MOTION: seg_len = $urandom_range(5, 30);
                default:    seg_len = $urandom_range(1, 6);
            endcase
            if (seg_len > left) seg_len = left;
            for (i = 0; i < seg_len; i++) begin
                s = '0;
                case (seg_kind)
                    SEG_STILL: begin
                        s.restart = (i == 0) && fresh_run;
                        s.acc.x   = around(bx, spread);
                        s.acc.y   = around(by, spread);
                        s.acc.z   = around(bz, spread);
                        s.rate.x  = around(0, rate_sp);
                        s.rate.y  = around(0, rate_sp);
                        s.rate.z  = around(0, rate_sp);
                    end
                    SEG_MOTION: begin
                        s.acc.x  = around(0, 20000);
                        s.acc.y  = around(0, 20000);
                        s.acc.z  = around(0, 20000);
                        s.rate.x = around(0, 20000);
                        s.rate.y = around(0, 20000);
                        s.rate.z = around(0, 20000);
                    end
                    SEG_NOISE: begin
                        s.restart = ($urandom_range(0, 15) == 0);
                        s.acc.x   = SMP_W'($urandom);
                        s.acc.y   = SMP_W'($urandom);
                        s.acc.z   = SMP_W'($urandom);
                        s.rate.x  = SMP_W'($urandom);
                        s.rate.y  = SMP_W'($urandom);
                        s.rate.z  = SMP_W'($urandom);
                    end
                    default: begin
                        s.acc.x  = corner_value();
                        s.acc.y  = corner_value();
                        s.acc.z  = corner_value();
                        s.rate.x = corner_value();
                        s.rate.y = corner_value();
                        s.rate.z = corner_value();
                    end
                endcase
                send_sample(s, 1'b0, none);
            end
            left -= seg_len;
        end
    endtask

    // result side: random ready gaps, one long hold when asked
    initial begin : result_sink
        int unsigned gap;
        bit          hold_done;
        hold_done = 1'b0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (rx_hold_req && !hold_done) begin
                hold_done = 1'b1;
                gap = HOLD_CYCLES;
            end
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin : check_verdict
        verdict_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            verdicts_seen++;
            if (m_valid_res === 1'b1) full_seen++;
            if (m_is_static === 1'b1) statics_seen++;
            if (verdicts_due.size() == 0) begin
                note_mismatch($sformatf("unexpected transfer, valid_res=%b is_static=%b",
                                        m_valid_res, m_is_static));
            end else begin
                want = verdicts_due.pop_front();
                if (m_valid_res !== want.valid_res)
                    note_mismatch($sformatf("valid_res expected %b got %b",
                                            want.valid_res, m_valid_res));
                if (m_is_static !== want.is_static)
                    note_mismatch($sformatf("is_static expected %b got %b",
                                            want.is_static, m_is_static));
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", stall_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : main_seq
        thresholds_t th;
        int          ph, i;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_RATE_LIMIT;
        cfg_data   = '0;
        s_valid    = 1'b0;
        s_restart  = 1'b0;
        s_accel_x  = '0;
        s_accel_y  = '0;
        s_accel_z  = '0;
        s_rate_x   = '0;
        s_rate_y   = '0;
        s_rate_z   = '0;
        rate_lim   = RATE_LIMIT_RST;
        spread_lim = SPREAD_LIMIT_RST;
        grav_lvl   = GRAVITY_LEVEL_RST;
        grav_tol   = GRAVITY_TOLERANCE_RST;
        clear_window_history();

        // fewer than HALF_WINDOW samples per run here, so every verdict is 0/0
        dir_tab[0]  = mk_row(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0);
        dir_tab[1]  = mk_row(0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 0, 0);
        dir_tab[2]  = mk_row(0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1, 0, 0);
        dir_tab[3]  = mk_row(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0, 0);
        dir_tab[4]  = mk_row(0, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1, 0, 0);
        dir_tab[5]  = mk_row(0, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1, 0, 0);
        dir_tab[6]  = mk_row(0, 16'h0000, 16'h0000, 16'd10045, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0);
        dir_tab[7]  = mk_row(0, 16'h0000, 16'h0000, 16'd10045, 16'd163, 16'h0000, 16'h0000, 1, 0, 0);
        dir_tab[8]  = mk_row(0, 16'h0000, 16'h0000, 16'd10045, 16'd164, 16'h0000, 16'h0000, 1, 0, 0);
        dir_tab[9]  = mk_row(0, 16'h0000, 16'h0000, 16'd10045, 16'h0000, 16'h0000, 16'hFF5C, 1, 0, 0);
        dir_tab[10] = mk_row(1, 16'h0000, 16'h0000, 16'd10045, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0);
        dir_tab[11] = mk_row(0, 16'd10045, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0);
        dir_tab[12] = mk_row(0, 16'h0000, 16'hD8CB, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0);
        dir_tab[13] = mk_row(0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0);
        dir_tab[14] = mk_row(0, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 1, 0, 0);
        dir_tab[15] = mk_row(1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1, 0, 0);
        dir_tab[16] = mk_row(1, 16'h0000, 16'h0000, 16'd10045, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0);
        dir_tab[17] = mk_row(0, 16'h0000, 16'h0000, 16'd10045, 16'd94, 16'd94, 16'd94, 1, 0, 0);
        dir_tab[18] = mk_row(0, 16'h0000, 16'h0000, 16'd10045, 16'd95, 16'd95, 16'd95, 1, 0, 0);
        dir_tab[19] = mk_row(0, 16'd5800, 16'd5800, 16'd5800, 16'h0001, 16'hFFFF, 16'h0001, 0, 0, 0);
        dir_tab[20] = mk_row(0, 16'hE441, 16'h0000, 16'h1BBF, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0);
        dir_tab[21] = mk_row(0, 16'h0000, 16'h0000, 16'd10045, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0);
        dir_tab[22] = mk_row(0, 16'h0001, 16'h0002, 16'h0004, 16'h0008, 16'h0010, 16'h0020, 1, 0, 0);
        dir_tab[23] = mk_row(0, 16'hFFFE, 16'hFFFD, 16'hFFFB, 16'hFFF7, 16'hFFEF, 16'hFFDF, 1, 0, 0);
        dir_tab[24] = mk_row(0, 16'h0000, 16'h0000, 16'd10045, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (i = 0; i < N_DIRECTED; i++) send_sample(dir_tab[i].smp, dir_tab[i].known, dir_tab[i].want);

        // phase 0 runs on the reset thresholds
        for (ph = 0; ph < N_PHASES; ph++) begin
            if (ph != 0) begin
                settle_idle();
                case (ph)
                    1:       th = '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF};
                    2:       th = '{15'd0, 15'd0, 15'd0, 15'd0};
                    3:       th = '{15'd400, 15'd300, 15'd10045, 15'd600};
                    4:       th = '{15'd200, 15'd200, 15'd500, 15'd12000}; // tolerance above gravity
                    default: th = '{CFG_W'($urandom_range(50, 600)), CFG_W'($urandom_range(30, 400)),
                                    CFG_W'($urandom_range(9000, 11000)),
                                    CFG_W'($urandom_range(0, 1500))};
                endcase
                write_reg(CFG_RATE_LIMIT, th.rate);
                write_reg(CFG_SPREAD_LIMIT, th.spread);
                write_reg(CFG_GRAVITY_LEVEL, th.grav);
                write_reg(CFG_GRAVITY_TOLERANCE, th.tol);
            end
            // long result-side hold: the pipeline fills and backs up into the input
            if (ph == 1) rx_hold_req = 1'b1;
            run_random(ITEMS_PER_PHASE);
        end

        s_valid <= 1'b0;
        for (i = 0; i < DRAIN_LIMIT && verdicts_due.size() != 0; i++) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (verdicts_due.size() != 0) begin
            $display("%0d expected verdicts never arrived", verdicts_due.size());
            mismatches += verdicts_due.size();
        end

        $display("Ran %0d samples through %0d threshold settings with restarts and a long stall",
                 samples_in, N_PHASES);
        $display("Checked %0d verdicts: %0d with history, %0d static; %0d mismatches",
                 verdicts_seen, full_seen, statics_seen, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/imu_swd_pkg.sv
sv/imu_static_window_detector_core.sv
dv/testbench.sv
